### rtl/core/idm_pkg.sv
// idm_pkg: shared types and constants for the idm acceleration block
// word layouts of the input and result channels, register indexes, reset values
// no dependencies
`default_nettype none

package idm_pkg;

  localparam int FRAC_BITS = 8;

  localparam int SPD_W     = 16;
  localparam int GAP_W     = 24;
  localparam int ACC_W     = 32;
  localparam int EXP_W     = 4;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_HEADWAY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMFORT_DECEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_EXP     = 3'd4;

  localparam logic [CFG_W-1:0] RST_MIN_GAP       = 16'd512;
  localparam logic [CFG_W-1:0] RST_TIME_HEADWAY  = 16'd384;
  localparam logic [CFG_W-1:0] RST_MAX_ACCEL     = 16'd256;
  localparam logic [CFG_W-1:0] RST_COMFORT_DECEL = 16'd384;
  localparam logic [EXP_W-1:0] RST_ACCEL_EXP     = 4'd4;

  // 0.1 m, rounded
  localparam logic [GAP_W-1:0] GAP_MIN = GAP_W'(((1 << FRAC_BITS) + 5) / 10);

  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
  localparam logic [63:0] CAP_Q32 = 64'h8000_0000_0000_0000;

  localparam logic [ACC_W-1:0] ACC_MAX_POS = 32'h7FFF_FFFF;
  localparam logic [ACC_W-1:0] ACC_MAX_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [SPD_W-1:0] speed;
    logic [SPD_W-1:0] desired_speed;
    logic [GAP_W-1:0] gap;
    logic [SPD_W-1:0] leader_speed;
  } in_word_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] accel;
    logic                    saturated;
  } out_word_t;

endpackage

`default_nettype wire

### rtl/core/idm_acceleration.sv
// idm_acceleration: pipelined intelligent driver model acceleration, one vehicle per word
// uses idm_pkg for word types, register indexes and constants
// contains the root sequencer, divider chains, power chain, output register and skid
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------
//  in_     | in  | in_valid / in_ready  | in_data   (in_word_t)
//  out_    | out | out_valid / out_ready| out_data  (out_word_t)
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one word enters per cycle while in_ready is high; the pipeline ends in the output register
// the pipeline length is set mostly by the two bit-per-stage dividers (48 stages each) and the
// fifteen two-stage power iterations
// after reset, and after a write of max_accel or comfort_decel, sqrt(a*b) is formed
// with in_ready low; cfg_ready is always high
// a stalled output parks one word in the skid stage, then the whole pipeline holds
`default_nettype none

module idm_acceleration
  import idm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_word_t             in_data,

  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_word_t                 out_data,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int F          = FRAC_BITS;
  localparam int RQ_W       = 48;          // quotient width of both Q32 ratios
  localparam int DQ_W       = 32 + F;      // numerator width of the dynamic term
  localparam int DIV_STAGES = 48;
  localparam int SW         = 33 + F;      // desired gap width
  localparam int CMP_W      = 40 + F;
  localparam int POW_ITERS  = 15;

  typedef enum logic [1:0] {SQ_LOAD, SQ_RUN, SQ_DONE} sq_state_t;

  typedef struct packed {
    logic                vz;
    logic [GAP_W-1:0]    g;
    logic [31:0]         vt;
    logic                neg;
    logic [SPD_W-1:0]    v0;
    logic [15:0]         r_rem;
    logic [RQ_W-1:0]     r_nq;
    logic [16:0]         d_rem;
    logic [DQ_W-1:0]     d_nq;
  } bdiv_t;

  typedef struct packed {
    logic                vz;
    logic [RQ_W-1:0]     ratio;
    logic                capq;
    logic [GAP_W-1:0]    g;
    logic [GAP_W-1:0]    rem;
    logic [RQ_W-1:0]     nq;
  } sdiv_t;

  typedef struct packed {
    logic                vz;
    logic [RQ_W-1:0]     ratio;
    logic                capq;
    logic [63:0]         ll;
    logic [47:0]         lh;
    logic [31:0]         hh;
  } sq_pp_t;

  typedef struct packed {
    logic                vz;
    logic [RQ_W-1:0]     ratio;
    logic [63:0]         q;
    logic [63:0]         p;
  } pw_t;

  typedef struct packed {
    logic                vz;
    logic [RQ_W-1:0]     ratio;
    logic [63:0]         q;
    logic [63:0]         p;
    logic [63:0]         ll;
    logic [47:0]         lh;
    logic [63:0]         hl;
    logic [47:0]         hh;
  } pm_t;

  typedef struct packed {
    logic        vz;
    logic [63:0] d;
  } fin1_t;

  typedef struct packed {
    logic        vz;
    logic        pos;
    logic        dcap;
    logic [63:0] mag;
  } fin2_t;

  typedef struct packed {
    logic        vz;
    logic        pos;
    logic        dcap;
    logic        az;
    logic [47:0] hi;
    logic [47:0] lo;
  } fin3_t;

  typedef struct packed {
    logic        vz;
    logic        pos;
    logic        dcap;
    logic        az;
    logic [63:0] res;
  } fin4_t;

  // restoring divider steps, one quotient bit each
  function automatic logic [16+RQ_W-1:0] ratio_step(input logic [15:0] rem,
                                                    input logic [RQ_W-1:0] nq,
                                                    input logic [15:0] dv);
    logic [16:0] sh;
    logic        qb;
    sh = {rem, nq[RQ_W-1]};
    qb = (sh >= {1'b0, dv});
    if (qb) sh = sh - {1'b0, dv};
    return {sh[15:0], nq[RQ_W-2:0], qb};
  endfunction

  function automatic logic [17+DQ_W-1:0] dyn_step(input logic [16:0] rem,
                                                  input logic [DQ_W-1:0] nq,
                                                  input logic [16:0] dv);
    logic [17:0] sh;
    logic        qb;
    sh = {rem, nq[DQ_W-1]};
    qb = (sh >= {1'b0, dv});
    if (qb) sh = sh - {1'b0, dv};
    return {sh[16:0], nq[DQ_W-2:0], qb};
  endfunction

  function automatic logic [GAP_W+RQ_W-1:0] sg_step(input logic [GAP_W-1:0] rem,
                                                   input logic [RQ_W-1:0] nq,
                                                   input logic [GAP_W-1:0] dv);
    logic [GAP_W:0] sh;
    logic           qb;
    sh = {rem, nq[RQ_W-1]};
    qb = (sh >= {1'b0, dv});
    if (qb) sh = sh - {1'b0, dv};
    return {sh[GAP_W-1:0], nq[RQ_W-2:0], qb};
  endfunction

  // configuration registers
  logic [CFG_W-1:0] min_gap_r, headway_r, accel_r, decel_r;
  logic [EXP_W-1:0] exp_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r <= RST_MIN_GAP;
      headway_r <= RST_TIME_HEADWAY;
      accel_r   <= RST_MAX_ACCEL;
      decel_r   <= RST_COMFORT_DECEL;
      exp_r     <= RST_ACCEL_EXP;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_GAP:       min_gap_r <= cfg_data;
        CFG_TIME_HEADWAY:  headway_r <= cfg_data;
        CFG_MAX_ACCEL:     accel_r   <= cfg_data;
        CFG_COMFORT_DECEL: decel_r   <= cfg_data;
        CFG_ACCEL_EXP:     exp_r     <= cfg_data[EXP_W-1:0];
        default: ;
      endcase
    end
  end

  // floor(sqrt(a*b)), two radicand bits per cycle
  sq_state_t   sq_state_r;
  logic [31:0] sq_n_r;
  logic [17:0] sq_rem_r;
  logic [15:0] sq_root_r;
  logic [3:0]  sq_cnt_r;
  logic [19:0] sq_sh, sq_trial;
  logic        cfg_ab_wr;
  logic [16:0] div_d;

  assign cfg_ab_wr = cfg_valid && (cfg_index == CFG_MAX_ACCEL ||
                                   cfg_index == CFG_COMFORT_DECEL);
  assign sq_sh     = {sq_rem_r, sq_n_r[31:30]};
  assign sq_trial  = {2'b00, sq_root_r, 2'b01};
  assign div_d     = {(sq_root_r == 16'd0) ? 16'd1 : sq_root_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_state_r <= SQ_LOAD;
      sq_cnt_r   <= 4'd0;
    end else if (cfg_ab_wr) begin
      sq_state_r <= SQ_LOAD;
    end else begin
      case (sq_state_r)
        SQ_LOAD: begin
          sq_n_r     <= 32'(accel_r) * 32'(decel_r);
          sq_rem_r   <= 18'd0;
          sq_root_r  <= 16'd0;
          sq_cnt_r   <= 4'd15;
          sq_state_r <= SQ_RUN;
        end
        SQ_RUN: begin
          if (sq_sh >= sq_trial) begin
            sq_rem_r  <= 18'(sq_sh - sq_trial);
            sq_root_r <= {sq_root_r[14:0], 1'b1};
          end else begin
            sq_rem_r  <= sq_sh[17:0];
            sq_root_r <= {sq_root_r[14:0], 1'b0};
          end
          sq_n_r   <= {sq_n_r[29:0], 2'b00};
          sq_cnt_r <= sq_cnt_r - 4'd1;
          if (sq_cnt_r == 4'd0) sq_state_r <= SQ_DONE;
        end
        SQ_DONE: ;
        default: sq_state_r <= SQ_LOAD;
      endcase
    end
  end

  // pipeline advance: whole pipe holds only while the skid stage is full
  logic      skid_v_r;
  logic      en;
  logic      acc_in;

  assign en       = !skid_v_r;
  assign in_ready = en && (sq_state_r == SQ_DONE);
  assign acc_in   = in_valid && in_ready;

  // stage 1: gap floor, v*T and v*|v - vL|
  logic             s1_v_r;
  logic             s1_vz_r, s1_neg_r;
  logic [GAP_W-1:0] s1_g_r;
  logic [31:0]      s1_vt_r, s1_vdv_r;
  logic [SPD_W-1:0] s1_v_r_spd, s1_v0_r;
  logic             in_neg;
  logic [SPD_W-1:0] in_diff;

  assign in_neg  = in_data.speed < in_data.leader_speed;
  assign in_diff = in_neg ? in_data.leader_speed - in_data.speed
                          : in_data.speed - in_data.leader_speed;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= acc_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_vz_r    <= (in_data.desired_speed == '0);
      s1_g_r     <= (in_data.gap < GAP_MIN) ? GAP_MIN : in_data.gap;
      s1_vt_r    <= 32'(in_data.speed) * 32'(headway_r);
      s1_vdv_r   <= 32'(in_data.speed) * 32'(in_diff);
      s1_neg_r   <= in_neg;
      s1_v_r_spd <= in_data.speed;
      s1_v0_r    <= in_data.desired_speed;
    end
  end

  // v/v0 and the dynamic term, side by side
  bdiv_t                 b_in;
  bdiv_t                 b_r   [DIV_STAGES];
  bdiv_t                 b_nxt [DIV_STAGES];
  logic [DIV_STAGES-1:0] b_v_r;

  always_comb begin
    b_in.vz    = s1_vz_r;
    b_in.g     = s1_g_r;
    b_in.vt    = s1_vt_r;
    b_in.neg   = s1_neg_r;
    b_in.v0    = s1_v0_r;
    b_in.r_rem = 16'd0;
    b_in.r_nq  = {s1_v_r_spd, 32'd0};
    b_in.d_rem = 17'd0;
    b_in.d_nq  = {s1_vdv_r, {F{1'b0}}};
  end

  always_comb begin
    bdiv_t bc;
    for (int k = 0; k < DIV_STAGES; k++) begin
      bc = (k == 0) ? b_in : b_r[k-1];
      b_nxt[k] = bc;
      {b_nxt[k].r_rem, b_nxt[k].r_nq} = ratio_step(bc.r_rem, bc.r_nq, bc.v0);
      if (k < DQ_W)
        {b_nxt[k].d_rem, b_nxt[k].d_nq} = dyn_step(bc.d_rem, bc.d_nq, div_d);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= '0;
    else if (en) b_v_r <= {b_v_r[DIV_STAGES-2:0], s1_v_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) b_r[k] <= b_nxt[k];
    end
  end

  // desired gap s and the cap test against the gap
  bdiv_t       b_last;
  logic [SW:0] rest_vt, rest_dyn, rest;
  logic [SW-1:0] s_gap;
  sdiv_t       c_in, c_r;
  logic        c_v_r;

  assign b_last = b_r[DIV_STAGES-1];

  always_comb begin
    rest_vt  = (SW+1)'(b_last.vt);
    rest_dyn = (SW+1)'(b_last.d_nq);
    rest     = b_last.neg ? rest_vt - rest_dyn : rest_vt + rest_dyn;
    if (rest[SW]) rest = '0;
    s_gap = rest[SW-1:0] + SW'({min_gap_r, {F{1'b0}}});
    c_in.vz    = b_last.vz;
    c_in.ratio = b_last.r_nq;
    c_in.capq  = CMP_W'(s_gap) >= {b_last.g, {(16+F){1'b0}}};
    c_in.g     = b_last.g;
    c_in.rem   = GAP_W'(s_gap[SW-1:16+F]);
    c_in.nq    = {s_gap[15+F:0], {(32-F){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (en) c_v_r <= b_v_r[DIV_STAGES-1];
  end

  always_ff @(posedge clk) begin
    if (en) c_r <= c_in;
  end

  // s/gap as Q32
  sdiv_t                 d_r   [DIV_STAGES];
  sdiv_t                 d_nxt [DIV_STAGES];
  logic [DIV_STAGES-1:0] d_v_r;

  always_comb begin
    sdiv_t dc;
    for (int k = 0; k < DIV_STAGES; k++) begin
      dc = (k == 0) ? c_r : d_r[k-1];
      d_nxt[k] = dc;
      {d_nxt[k].rem, d_nxt[k].nq} = sg_step(dc.rem, dc.nq, dc.g);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= '0;
    else if (en) d_v_r <= {d_v_r[DIV_STAGES-2:0], c_v_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) d_r[k] <= d_nxt[k];
    end
  end

  // q = (s/gap)^2: partial products, then sum and cap
  sdiv_t  d_last;
  sq_pp_t e1_r;
  logic   e1_v_r;
  pw_t    e2_r;
  logic   e2_v_r;
  logic [64:0] q_sum;

  assign d_last = d_r[DIV_STAGES-1];
  assign q_sum  = 65'({e1_r.hh, 32'd0}) + 65'({e1_r.lh, 1'b0}) + 65'(e1_r.ll[63:32]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
    end else if (en) begin
      e1_v_r <= d_v_r[DIV_STAGES-1];
      e2_v_r <= e1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r.vz    <= d_last.vz;
      e1_r.ratio <= d_last.ratio;
      e1_r.capq  <= d_last.capq;
      e1_r.ll    <= 64'(d_last.nq[31:0]) * 64'(d_last.nq[31:0]);
      e1_r.lh    <= 48'(d_last.nq[31:0]) * 48'(d_last.nq[47:32]);
      e1_r.hh    <= 32'(d_last.nq[47:32]) * 32'(d_last.nq[47:32]);
      e2_r.vz    <= e1_r.vz;
      e2_r.ratio <= e1_r.ratio;
      e2_r.q     <= (e1_r.capq || q_sum >= 65'(CAP_Q32)) ? CAP_Q32 : q_sum[63:0];
      e2_r.p     <= ONE_Q32;
    end
  end

  // p = (v/v0)^delta, one saturating Q32 product per iteration
  pm_t                  pm_r   [POW_ITERS];
  pm_t                  pm_nxt [POW_ITERS];
  pw_t                  pw_r   [POW_ITERS];
  pw_t                  pw_nxt [POW_ITERS];
  logic [POW_ITERS-1:0] pm_v_r, pw_v_r;

  always_comb begin
    pw_t         pc;
    logic [80:0] psum;
    logic [63:0] prod;
    for (int j = 0; j < POW_ITERS; j++) begin
      pc = (j == 0) ? e2_r : pw_r[j-1];
      pm_nxt[j].vz    = pc.vz;
      pm_nxt[j].ratio = pc.ratio;
      pm_nxt[j].q     = pc.q;
      pm_nxt[j].p     = pc.p;
      pm_nxt[j].ll    = 64'(pc.p[31:0]) * 64'(pc.ratio[31:0]);
      pm_nxt[j].lh    = 48'(pc.p[31:0]) * 48'(pc.ratio[47:32]);
      pm_nxt[j].hl    = 64'(pc.p[63:32]) * 64'(pc.ratio[31:0]);
      pm_nxt[j].hh    = 48'(pc.p[63:32]) * 48'(pc.ratio[47:32]);

      psum = 81'({pm_r[j].hh, 32'd0}) + 81'(pm_r[j].hl) + 81'(pm_r[j].lh)
           + 81'(pm_r[j].ll[63:32]);
      prod = (psum >= 81'(CAP_Q32)) ? CAP_Q32 : psum[63:0];
      pw_nxt[j].vz    = pm_r[j].vz;
      pw_nxt[j].ratio = pm_r[j].ratio;
      pw_nxt[j].q     = pm_r[j].q;
      pw_nxt[j].p     = (EXP_W'(j) < exp_r) ? prod : pm_r[j].p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_v_r <= '0;
      pw_v_r <= '0;
    end else if (en) begin
      pm_v_r <= {pw_v_r[POW_ITERS-2:0], e2_v_r};
      pw_v_r <= pm_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < POW_ITERS; j++) begin
        pm_r[j] <= pm_nxt[j];
        pw_r[j] <= pw_nxt[j];
      end
    end
  end

  // d = p + q, magnitude against one, scale by a, clip
  pw_t         pw_last;
  fin1_t       f1_r;
  fin2_t       f2_r;
  fin3_t       f3_r;
  fin4_t       f4_r;
  out_word_t   f5_r;
  logic        f1_v_r, f2_v_r, f3_v_r, f4_v_r, f5_v_r;
  logic [64:0] d_sum;
  out_word_t   fin_word;

  assign pw_last = pw_r[POW_ITERS-1];
  assign d_sum   = 65'(pw_last.p) + 65'(pw_last.q);

  always_comb begin
    fin_word.saturated = 1'b0;
    if (f4_r.vz) begin
      fin_word.accel     = ACC_MAX_NEG;
      fin_word.saturated = 1'b1;
    end else if (f4_r.pos) begin
      if (f4_r.res > 64'(ACC_MAX_POS)) begin
        fin_word.accel     = ACC_MAX_POS;
        fin_word.saturated = 1'b1;
      end else begin
        fin_word.accel = f4_r.res[31:0];
      end
    end else if (f4_r.dcap && !f4_r.az) begin
      fin_word.accel     = ACC_MAX_NEG;
      fin_word.saturated = 1'b1;
    end else if (f4_r.res > 64'(ACC_MAX_NEG)) begin
      fin_word.accel     = ACC_MAX_NEG;
      fin_word.saturated = 1'b1;
    end else begin
      fin_word.accel = 32'(32'd0 - f4_r.res[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
      f4_v_r <= 1'b0;
      f5_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= pw_v_r[POW_ITERS-1];
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
      f4_v_r <= f3_v_r;
      f5_v_r <= f4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r.vz   <= pw_last.vz;
      f1_r.d    <= (d_sum >= 65'(CAP_Q32)) ? CAP_Q32 : d_sum[63:0];

      f2_r.vz   <= f1_r.vz;
      f2_r.pos  <= (f1_r.d <= ONE_Q32);
      f2_r.dcap <= (f1_r.d == CAP_Q32);
      f2_r.mag  <= (f1_r.d <= ONE_Q32) ? ONE_Q32 - f1_r.d : f1_r.d - ONE_Q32;

      f3_r.vz   <= f2_r.vz;
      f3_r.pos  <= f2_r.pos;
      f3_r.dcap <= f2_r.dcap;
      f3_r.az   <= (accel_r == '0);
      f3_r.hi   <= 48'(accel_r) * 48'(f2_r.mag[63:32]);
      f3_r.lo   <= 48'(accel_r) * 48'(f2_r.mag[31:0]);

      f4_r.vz   <= f3_r.vz;
      f4_r.pos  <= f3_r.pos;
      f4_r.dcap <= f3_r.dcap;
      f4_r.az   <= f3_r.az;
      f4_r.res  <= (64'(f3_r.hi) << (16 - F)) + 64'(f3_r.lo >> (16 + F));

      f5_r      <= fin_word;
    end
  end

  // output register with one skid stage behind it
  logic      out_valid_r;
  out_word_t out_word_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= f5_v_r;
      end
    end else if (en && f5_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_word_r <= skid_v_r ? skid_r : f5_r;
    end else if (en && f5_v_r) begin
      skid_r <= f5_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

`default_nettype wire
